[rtl/htmc_pkg.sv]
`default_nettype none

package htmc_pkg;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_CTRL   = 3'd0;
    localparam logic [2:0] OP_FAST   = 3'd1;
    localparam logic [2:0] OP_ARM    = 3'd2;
    localparam logic [2:0] OP_TARGET = 3'd3;
    localparam logic [2:0] OP_MODE   = 3'd4;

    // Height modes.
    localparam logic [1:0] HM_MANUAL  = 2'd0;
    localparam logic [1:0] HM_AUTO    = 2'd1;
    localparam logic [1:0] HM_TAKEOFF = 2'd2;
    localparam logic [1:0] HM_LANDING = 2'd3;

    // Vertical setpoint modes.
    localparam logic [1:0] ZM_DISABLED = 2'd0;
    localparam logic [1:0] ZM_ABS      = 2'd1;
    localparam logic [1:0] ZM_VEL      = 2'd2;
    localparam logic [1:0] ZM_KEEP     = 2'd3;

    // Divider job kinds, which select how the quotient is used.
    localparam logic [1:0] DK_BLEND  = 2'd0;
    localparam logic [1:0] DK_MANUAL = 2'd1;
    localparam logic [1:0] DK_LAND   = 2'd2;
    localparam logic [1:0] DK_FAST   = 2'd3;

    // Thrust constants.
    localparam int THR_HOVER   = 20000;
    localparam int THR_LAND    = 15000;
    localparam int THR_MIN     = 10000;
    localparam int THR_MAX     = 50000;
    localparam int ADJ_MIN     = -8000;
    localparam int ADJ_MAX     = 12000;
    localparam int DEAD_ZONE   = 1280;    // 5 cm in Q16.8
    localparam int NEAR_ZONE   = 5120;    // 20 cm in Q16.8
    localparam int LAND_VEL    = -12800;  // -50 cm/s in Q16.8

    // Widths of the shared arithmetic.
    localparam int DIV_QW  = 41;  // dividend magnitude bits
    localparam int DIV_YW  = 25;  // divisor bits
    localparam int WIDE_W  = 44;  // working width of sums and products

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [23:0] q16_t;

endpackage

`default_nettype wire

[rtl/height_thrust_mode_controller_top.sv]
`default_nettype none

// Height thrust controller. One input beat is taken at a time and gives one result beat.
// Set-target, set-mode, arm and absolute-mode fast ticks finish at acceptance; a control
// tick and a velocity-mode fast tick run through the sequencer to their result beat, using
// one shared 26x18 multiplier and a restoring divider that retires one quotient bit
// per cycle (range blend; manual or landing thrust; velocity-mode fast tick).
// manual_thrust is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, since the block itself does not enforce this.
module height_thrust_mode_controller_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic signed [23:0] s_est_height,
    input  wire logic        s_tof_valid,
    input  wire logic [15:0] s_tof_distance_mm,
    input  wire logic signed [23:0] s_baro_altitude,
    input  wire logic signed [23:0] s_est_position_z,
    input  wire logic [15:0] s_vel_ticks,
    input  wire logic [15:0] s_abs_ticks,
    input  wire logic signed [23:0] s_height_value,
    input  wire logic [1:0]  s_mode_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_base_thrust,
    output logic [1:0]       m_z_mode,
    output logic [15:0]      m_thrust_setpoint,
    output logic signed [23:0] m_z_position_target,
    output logic signed [23:0] m_z_velocity_target,
    output logic             m_vel_override_valid,
    output logic signed [23:0] m_vel_override,
    output logic             m_reset_height_est,
    output logic             m_reset_all_est
);
    import htmc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_BLEND1   = 4'd1;
    localparam logic [3:0] ST_BLEND2   = 4'd2;
    localparam logic [3:0] ST_BLENDSUM = 4'd3;
    localparam logic [3:0] ST_DIV      = 4'd4;
    localparam logic [3:0] ST_DIVEND   = 4'd5;
    localparam logic [3:0] ST_MODESEL  = 4'd6;
    localparam logic [3:0] ST_LANDMUL  = 4'd7;
    localparam logic [3:0] ST_LANDDIV  = 4'd8;
    localparam logic [3:0] ST_AUTOMUL  = 4'd9;
    localparam logic [3:0] ST_AUTOEND  = 4'd10;
    localparam logic [3:0] ST_FASTMUL  = 4'd11;
    localparam logic [3:0] ST_FASTDIV  = 4'd12;
    localparam logic [3:0] ST_FIN      = 4'd13;

    // Controller state.
    logic [3:0]  state_reg, state_next;
    logic [15:0] man_reg, man_next;
    logic [1:0]  hmode_reg, hmode_next;
    q16_t        target_reg, target_next;
    logic [15:0] thr_reg, thr_next;
    logic [15:0] vcnt_reg, vcnt_next;
    logic [15:0] acnt_reg, acnt_next;
    q16_t        bprev_reg, bprev_next;
    q16_t        bvf_reg, bvf_next;

    // Latched operands and working registers.
    q16_t        est_reg, est_next;
    logic [15:0] mm_reg, mm_next;
    q16_t        baro_reg, baro_next;
    q16_t        posz_reg, posz_next;
    q16_t        fused_reg, fused_next;
    wide_t       acc_reg, acc_next;
    wide_t       prod_reg, prod_next;
    wide_t       t_reg, t_next;
    logic        fast_reg, fast_next;

    // Divider registers.
    logic [DIV_QW-1:0] dq_reg, dq_next;
    logic [DIV_YW-1:0] dr_reg, dr_next;
    logic [DIV_YW-1:0] dy_reg, dy_next;
    logic              dneg_reg, dneg_next;
    logic [5:0]        dcnt_reg, dcnt_next;
    logic [1:0]        dkind_reg, dkind_next;

    // Output register.
    logic        mv_reg, mv_next;
    logic [15:0] o_base_reg, o_base_next;
    logic [1:0]  o_zm_reg, o_zm_next;
    logic [15:0] o_tsp_reg, o_tsp_next;
    q16_t        o_ptgt_reg, o_ptgt_next;
    q16_t        o_vtgt_reg, o_vtgt_next;
    logic        o_ovv_reg, o_ovv_next;
    q16_t        o_ov_reg, o_ov_next;
    logic        o_rh_reg, o_rh_next;
    logic        o_ra_reg, o_ra_next;

    // Shared multiplier operands.
    logic signed [25:0] mul_a;
    logic signed [17:0] mul_b;
    wide_t              mul_p;

    // Shared divider load.
    logic              div_load;
    wide_t             div_x;
    logic [DIV_YW-1:0] div_y;
    logic [1:0]        div_kind;
    wide_t             div_mag;

    // Misc combinational values.
    logic        accept;
    logic        out_free;
    logic [16:0] mmx;
    logic [19:0] k1;
    logic [13:0] w14;
    logic signed [24:0] err;
    logic [24:0] ae;
    logic signed [24:0] bdiff;
    wide_t       quo;
    wide_t       qmag;
    logic [25:0] dsh;
    logic [26:0] ddiff;
    wide_t       blend_n;
    wide_t       land_num;
    logic [23:0] tgt_abs;
    wide_t       fast_d;
    wide_t       fast_n7;
    wide_t       fsum;
    q16_t        fsat;
    wide_t       small_s;
    wide_t       large_s;
    wide_t       t_clamp;
    logic        blend_ok;

    assign accept   = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    assign blend_ok = s_tof_valid && (s_tof_distance_mm != 16'd0)
                      && (s_tof_distance_mm < 16'd2000);

    // Blend weights; only used while the range is below 2000 mm.
    assign mmx = {1'b0, mm_reg} + 17'd3000;
    assign k1  = ({3'b0, mmx} << 3) + ({3'b0, mmx} << 1);
    assign w14 = 14'd7000 - mm_reg[13:0];

    // Height error for auto and takeoff.
    assign err = {target_reg[23], target_reg} - {fused_reg[23], fused_reg};
    assign ae  = err[24] ? 25'(-err) : 25'(err);

    assign bdiff = {baro_reg[23], baro_reg} - {bprev_reg[23], bprev_reg};

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_BLEND1: begin
                mul_a = 26'(est_reg);
                mul_b = {1'b0, k1[16:0]};
            end
            ST_BLEND2: begin
                mul_a = {10'b0, mm_reg};
                mul_b = {4'b0, w14};
            end
            ST_LANDMUL: begin
                mul_a = 26'(fused_reg);
                mul_b = 18'sd5000;
            end
            ST_AUTOMUL: begin
                mul_a = 26'(err);
                mul_b = (ae < 25'(NEAR_ZONE)) ? {4'b0, ae[13:0]} : 18'sd100;
            end
            ST_FASTMUL: begin
                mul_a = 26'(bdiff);
                mul_b = 18'sd250;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider step and signed floor quotient.
    assign dsh   = {dr_reg, dq_reg[DIV_QW-1]};
    assign ddiff = {1'b0, dsh} - {2'b0, dy_reg};
    assign qmag  = {{(WIDE_W-DIV_QW){1'b0}}, dq_reg}
                   + ((dneg_reg && dr_reg != '0) ? 44'sd1 : 44'sd0);
    assign quo   = dneg_reg ? -qmag : qmag;
    assign div_mag = div_x[WIDE_W-1] ? -div_x : div_x;

    // Dividend forms for each job.
    assign blend_n  = acc_reg + (prod_reg <<< 8);
    assign land_num = target_reg[23] ? -prod_reg : prod_reg;
    assign tgt_abs  = target_reg[23] ? 24'(-target_reg) : 24'(target_reg);
    assign fast_d   = prod_reg - WIDE_W'(bvf_reg);
    assign fast_n7  = (fast_d <<< 3) - fast_d;

    // Filter update with 24-bit saturation.
    assign fsum = WIDE_W'(bvf_reg) + quo;
    assign fsat = (fsum > 44'sd8388607) ? 24'sh7fffff :
                  (fsum < -44'sd8388608) ? 24'sh800000 : fsum[23:0];

    // Auto thrust adjustments.
    assign small_s = ((prod_reg <<< 2) + prod_reg + 44'sd32768) >>> 16;
    assign large_s = (prod_reg + 44'sd128) >>> 8;

    assign t_clamp = (t_reg < WIDE_W'(THR_MIN)) ? WIDE_W'(THR_MIN) :
                     (t_reg > WIDE_W'(THR_MAX)) ? WIDE_W'(THR_MAX) : t_reg;

    // Negation with saturation of the committed filter value.
    function automatic q16_t fneg_keep(input q16_t v);
        fneg_keep = (v == 24'sh800000) ? 24'sh7fffff : -v;
    endfunction

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        man_next    = cfg_we ? cfg_wdata : man_reg;
        hmode_next  = hmode_reg;
        target_next = target_reg;
        thr_next    = thr_reg;
        vcnt_next   = vcnt_reg;
        acnt_next   = acnt_reg;
        bprev_next  = bprev_reg;
        bvf_next    = bvf_reg;
        est_next    = est_reg;
        mm_next     = mm_reg;
        baro_next   = baro_reg;
        posz_next   = posz_reg;
        fused_next  = fused_reg;
        acc_next    = acc_reg;
        prod_next   = mul_p;
        t_next      = t_reg;
        fast_next   = fast_reg;
        dq_next     = dq_reg;
        dr_next     = dr_reg;
        dy_next     = dy_reg;
        dneg_next   = dneg_reg;
        dcnt_next   = dcnt_reg;
        dkind_next  = dkind_reg;
        mv_next     = mv_reg && !m_ready;
        o_base_next = o_base_reg;
        o_zm_next   = o_zm_reg;
        o_tsp_next  = o_tsp_reg;
        o_ptgt_next = o_ptgt_reg;
        o_vtgt_next = o_vtgt_reg;
        o_ovv_next  = o_ovv_reg;
        o_ov_next   = o_ov_reg;
        o_rh_next   = o_rh_reg;
        o_ra_next   = o_ra_reg;
        div_load    = 1'b0;
        div_x       = '0;
        div_y       = '0;
        div_kind    = DK_BLEND;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    est_next  = s_est_height;
                    mm_next   = s_tof_distance_mm;
                    baro_next = s_baro_altitude;
                    posz_next = s_est_position_z;
                    // Beats that finish at once load the output register here.
                    o_base_next = thr_reg;
                    o_zm_next   = ZM_KEEP;
                    o_tsp_next  = '0;
                    o_ptgt_next = '0;
                    o_vtgt_next = '0;
                    o_ovv_next  = 1'b0;
                    o_ov_next   = '0;
                    o_rh_next   = 1'b0;
                    o_ra_next   = 1'b0;
                    case (s_op)
                        OP_CTRL: begin
                            fast_next = 1'b0;
                            if (blend_ok) begin
                                state_next = ST_BLEND1;
                            end else begin
                                fused_next = s_est_height;
                                state_next = ST_MODESEL;
                            end
                        end
                        OP_FAST: begin
                            if (vcnt_reg != 16'd0) begin
                                fast_next  = 1'b1;
                                state_next = ST_FASTMUL;
                            end else if (acnt_reg != 16'd0) begin
                                acnt_next   = acnt_reg - 16'd1;
                                o_ra_next   = 1'b1;
                                o_zm_next   = ZM_ABS;
                                o_ptgt_next = target_reg;
                                mv_next     = 1'b1;
                            end else begin
                                mv_next = 1'b1;
                            end
                        end
                        OP_ARM: begin
                            if (s_vel_ticks != 16'd0 && vcnt_reg == 16'd0) begin
                                bprev_next = s_baro_altitude;
                                bvf_next   = '0;
                                vcnt_next  = s_vel_ticks;
                            end
                            if (s_abs_ticks != 16'd0 && acnt_reg == 16'd0) begin
                                target_next = s_height_value;
                                acnt_next   = s_abs_ticks;
                                hmode_next  = HM_AUTO;
                            end
                            mv_next = 1'b1;
                        end
                        OP_TARGET: begin
                            target_next = s_height_value;
                            hmode_next  = HM_AUTO;
                            mv_next     = 1'b1;
                        end
                        OP_MODE: begin
                            hmode_next = s_mode_value;
                            mv_next    = 1'b1;
                        end
                        default: begin
                            mv_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BLEND1: begin
                state_next = ST_BLEND2;
            end
            ST_BLEND2: begin
                acc_next   = prod_reg;
                state_next = ST_BLENDSUM;
            end
            ST_BLENDSUM: begin
                div_load   = 1'b1;
                div_x      = (blend_n <<< 1) + 44'sd100000;
                div_y      = 25'd200000;
                div_kind   = DK_BLEND;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                dr_next   = ddiff[26] ? dsh[DIV_YW-1:0] : ddiff[DIV_YW-1:0];
                dq_next   = {dq_reg[DIV_QW-2:0], !ddiff[26]};
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd1) begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                case (dkind_reg)
                    DK_BLEND: begin
                        fused_next = quo[23:0];
                        state_next = ST_MODESEL;
                    end
                    DK_MANUAL: begin
                        t_next     = WIDE_W'(THR_HOVER) + quo;
                        state_next = ST_FIN;
                    end
                    DK_LAND: begin
                        t_next     = WIDE_W'(THR_LAND) + quo;
                        state_next = ST_FIN;
                    end
                    default: begin
                        // Velocity-mode fast tick: commit filter and countdown.
                        bvf_next   = fsat;
                        bprev_next = baro_reg;
                        vcnt_next  = vcnt_reg - 16'd1;
                        if (vcnt_reg == 16'd1) begin
                            target_next = posz_reg;
                        end
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MODESEL: begin
                unique case (hmode_reg)
                    HM_MANUAL: begin
                        div_load   = 1'b1;
                        div_x      = WIDE_W'({man_reg, 2'b0}) + WIDE_W'({man_reg, 1'b0})
                                     + 44'sd10;
                        div_y      = 25'd20;
                        div_kind   = DK_MANUAL;
                        state_next = ST_DIV;
                    end
                    HM_LANDING: begin
                        if (target_reg == '0) begin
                            t_next = (fused_reg > 0) ? WIDE_W'(THR_MAX) :
                                     (fused_reg < 0) ? WIDE_W'(THR_MIN) : WIDE_W'(THR_LAND);
                            state_next = ST_FIN;
                        end else begin
                            state_next = ST_LANDMUL;
                        end
                    end
                    default: begin
                        if (ae > 25'(DEAD_ZONE)) begin
                            state_next = ST_AUTOMUL;
                        end else begin
                            t_next     = WIDE_W'(THR_HOVER);
                            state_next = ST_FIN;
                        end
                    end
                endcase
            end
            ST_LANDMUL: begin
                state_next = ST_LANDDIV;
            end
            ST_LANDDIV: begin
                div_load   = 1'b1;
                div_x      = (land_num <<< 1) + WIDE_W'({1'b0, tgt_abs});
                div_y      = {tgt_abs, 1'b0};
                div_kind   = DK_LAND;
                state_next = ST_DIV;
            end
            ST_AUTOMUL: begin
                state_next = ST_AUTOEND;
            end
            ST_AUTOEND: begin
                if (ae < 25'(NEAR_ZONE)) begin
                    t_next = WIDE_W'(THR_HOVER) + small_s;
                end else if (large_s < WIDE_W'(ADJ_MIN)) begin
                    t_next = WIDE_W'(THR_HOVER + ADJ_MIN);
                end else if (large_s > WIDE_W'(ADJ_MAX)) begin
                    t_next = WIDE_W'(THR_HOVER + ADJ_MAX);
                end else begin
                    t_next = WIDE_W'(THR_HOVER) + large_s;
                end
                state_next = ST_FIN;
            end
            ST_FASTMUL: begin
                state_next = ST_FASTDIV;
            end
            ST_FASTDIV: begin
                div_load   = 1'b1;
                div_x      = (fast_n7 <<< 1) + 44'sd20;
                div_y      = 25'd40;
                div_kind   = DK_FAST;
                state_next = ST_DIV;
            end
            ST_FIN: begin
                // Hold until the output register can take the result beat.
                if (out_free) begin
                    mv_next     = 1'b1;
                    o_tsp_next  = '0;
                    o_ptgt_next = '0;
                    o_vtgt_next = '0;
                    o_ovv_next  = 1'b0;
                    o_ov_next   = '0;
                    o_rh_next   = 1'b0;
                    o_ra_next   = 1'b0;
                    if (fast_reg) begin
                        o_base_next = thr_reg;
                        o_zm_next   = ZM_VEL;
                        o_vtgt_next = fneg_keep(bvf_reg);
                        o_ovv_next  = 1'b1;
                        o_ov_next   = bvf_reg;
                        o_rh_next   = 1'b1;
                    end else begin
                        thr_next    = t_clamp[15:0];
                        o_base_next = t_clamp[15:0];
                        unique case (hmode_reg)
                            HM_MANUAL: begin
                                o_zm_next  = ZM_DISABLED;
                                o_tsp_next = man_reg;
                            end
                            HM_LANDING: begin
                                o_zm_next   = ZM_VEL;
                                o_vtgt_next = 24'(LAND_VEL);
                            end
                            default: begin
                                o_zm_next   = ZM_ABS;
                                o_ptgt_next = target_reg;
                            end
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start of a division job.
        if (div_load) begin
            dneg_next  = div_x[WIDE_W-1];
            dq_next    = div_mag[DIV_QW-1:0];
            dr_next    = '0;
            dy_next    = div_y;
            dcnt_next  = 6'(DIV_QW);
            dkind_next = div_kind;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            man_reg    <= '0;
            hmode_reg  <= HM_MANUAL;
            target_reg <= '0;
            thr_reg    <= 16'(THR_HOVER);
            vcnt_reg   <= '0;
            acnt_reg   <= '0;
            bprev_reg  <= '0;
            bvf_reg    <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            man_reg    <= man_next;
            hmode_reg  <= hmode_next;
            target_reg <= target_next;
            thr_reg    <= thr_next;
            vcnt_reg   <= vcnt_next;
            acnt_reg   <= acnt_next;
            bprev_reg  <= bprev_next;
            bvf_reg    <= bvf_next;
            mv_reg     <= mv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        est_reg     <= est_next;
        mm_reg      <= mm_next;
        baro_reg    <= baro_next;
        posz_reg    <= posz_next;
        fused_reg   <= fused_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        t_reg       <= t_next;
        fast_reg    <= fast_next;
        dq_reg      <= dq_next;
        dr_reg      <= dr_next;
        dy_reg      <= dy_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
        dkind_reg   <= dkind_next;
        o_base_reg  <= o_base_next;
        o_zm_reg    <= o_zm_next;
        o_tsp_reg   <= o_tsp_next;
        o_ptgt_reg  <= o_ptgt_next;
        o_vtgt_reg  <= o_vtgt_next;
        o_ovv_reg   <= o_ovv_next;
        o_ov_reg    <= o_ov_next;
        o_rh_reg    <= o_rh_next;
        o_ra_reg    <= o_ra_next;
    end

    assign m_valid              = mv_reg;
    assign m_base_thrust        = o_base_reg;
    assign m_z_mode             = o_zm_reg;
    assign m_thrust_setpoint    = o_tsp_reg;
    assign m_z_position_target  = o_ptgt_reg;
    assign m_z_velocity_target  = o_vtgt_reg;
    assign m_vel_override_valid = o_ovv_reg;
    assign m_vel_override       = o_ov_reg;
    assign m_reset_height_est   = o_rh_reg;
    assign m_reset_all_est      = o_ra_reg;

    // The stored base thrust always stays within the safety range.
    a_thr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (thr_reg >= 16'(THR_MIN)) && (thr_reg <= 16'(THR_MAX)))
        else $error("base thrust left its safety range");

    // A height-estimate reset beat always carries the velocity override.
    a_rh_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reset_height_est) |-> (m_z_mode == ZM_VEL) && m_vel_override_valid)
        else $error("height reset pulse without velocity override");

    // A new beat is never taken while a result beat is stalled.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |-> !s_ready)
        else $error("input accepted over a stalled result");

    // A division job runs its full length before its result is used.
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVEND) |-> ($past(state_reg) == ST_DIV) && (dcnt_reg == 6'd0))
        else $error("divider finished early");

endmodule

`default_nettype wire
